### hdl/shv_pkg.sv
// shv_pkg: constants, types and helper functions of the swap header validator
// shared by the interfaces, the front, the queue, the back and the top level
package shv_pkg;

    // page layout
    localparam int PAGE_BYTES      = 4096;
    localparam int SIGNATURE_BYTES = 10;
    localparam int LIST_OFFSET     = 1536;
    localparam int WORD_BYTES      = 4;
    localparam int VER_AT          = 1024;
    localparam int LAST_AT         = 1028;
    localparam int COUNT_AT        = 1032;

    localparam int SIG_START = PAGE_BYTES - SIGNATURE_BYTES;
    localparam int MAX_BAD   = (PAGE_BYTES - SIGNATURE_BYTES - LIST_OFFSET) / WORD_BYTES;

    // widths
    localparam int POS_W  = $clog2(PAGE_BYTES + 1);
    localparam int IDX_W  = $clog2(MAX_BAD + 1);
    localparam int WORD_W = 32;
    localparam int DEV_W  = 33;
    localparam int BPC_W  = 10;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_VALID   = 2'd0,
        ST_NO_SIG  = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // what a header byte means to the back part
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_VERSION = 3'd1,
        OP_LAST    = 3'd2,
        OP_COUNT   = 3'd3,
        OP_LIST    = 3'd4
    } op_kind_t;

    // one classified beat travelling from front to back
    typedef struct packed {
        logic              last;
        logic              right_length;
        logic              sig_bad;
        op_kind_t          kind;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
    } q_entry_t;

    function automatic logic [7:0] sig_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0:    c = 8'h53; // S
            4'd1:    c = 8'h57; // W
            4'd2:    c = 8'h41; // A
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h53; // S
            4'd5:    c = 8'h50; // P
            4'd6:    c = 8'h41; // A
            4'd7:    c = 8'h43; // C
            4'd8:    c = 8'h45; // E
            4'd9:    c = 8'h32; // 2
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

### hdl/shv_if.sv
// shv_if: valid/ready channels of the swap header validator
// depends on shv_pkg for field widths
interface shv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface shv_verdict_if;
    logic                             valid;
    logic                             ready;
    logic [shv_pkg::STAT_W-1:0]       status;
    logic                             big_endian;
    logic [shv_pkg::WORD_W-1:0]       last_page;
    logic [shv_pkg::BPC_W-1:0]        bad_page_count;

    modport source (output valid, output status, output big_endian, output last_page,
                    output bad_page_count, input ready);
    modport sink   (input valid, input status, input big_endian, input last_page,
                    input bad_page_count, output ready);
endinterface

### hdl/swap_header_validator_unit.sv
// swap_header_validator_unit: top level of the swap header validator
// depends on shv_pkg, shv_if, shv_front, shv_queue and shv_back
//
// usage
//   in_ch carries one header byte per beat, in address order; last_byte marks
//   the final beat of a header. out_ch carries one verdict per header: status
//   (valid, signature missing, or invalid, also for a wrong length), byte order,
//   last page and bad page count, the last three zero unless the header is valid.
//   cfg_wr_en / cfg_wr_data load the device page count (33 bits), which the
//   last page must stay below; write it only while no header is in flight.
// timing
//   one beat per cycle unless a verdict stalls; the front takes a beat
//   whenever the two-entry queue has room, and the back drains one entry per
//   cycle; the last beat goes through the queue to the back's verdict register
// reset
//   rst_n clears byte position, all checks, the queue and out_ch.valid; the
//   device page count returns to zero
// stall
//   while out_ch holds an untaken verdict, the back keeps draining beats of the
//   next header and stops only at its last beat; the queue then fills and
//   in_ch.ready drops
module swap_header_validator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [shv_pkg::DEV_W-1:0]   cfg_wr_data,
    shv_byte_if.sink                    in_ch,
    shv_verdict_if.source               out_ch
);

    // device page count register
    logic [shv_pkg::DEV_W-1:0] dev_pages_reg, dev_pages_next;

    // front to queue
    shv_pkg::q_entry_t front_entry;
    logic              q_full;
    logic              in_accept;

    // queue to back
    shv_pkg::q_entry_t q_head;
    logic              q_not_empty;
    logic              q_pop;

    assign in_ch.ready    = !q_full;
    assign in_accept      = in_ch.valid && !q_full;
    assign dev_pages_next = cfg_wr_en ? cfg_wr_data : dev_pages_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_pages_reg <= '0;
        else
            dev_pages_reg <= dev_pages_next;
    end

    // position tracking, word assembly, signature compare, classification
    shv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .entry     (front_entry)
    );

    // decouples byte intake from a stalled verdict
    shv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_head)
    );

    // header checks and verdict register
    shv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dev_pages (dev_pages_reg),
        .q_valid   (q_not_empty),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

    // a rejected header reports no byte order, page or count
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != shv_pkg::ST_VALID
        |-> !out_ch.big_endian && out_ch.last_page == '0 && out_ch.bad_page_count == '0)
        else $error("rejected header carries nonzero fields");

    // an accepted header has a last page inside the device
    a_page_in_dev: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == shv_pkg::ST_VALID
        |-> out_ch.last_page != '0 && {1'b0, out_ch.last_page} < dev_pages_reg)
        else $error("valid verdict with last page outside device");

    // an accepted header lists no more bad pages than fit
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == shv_pkg::ST_VALID
        |-> out_ch.bad_page_count <= shv_pkg::BPC_W'(shv_pkg::MAX_BAD))
        else $error("valid verdict with bad page count over capacity");

    // a beat is never taken while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_accept)
        else $error("queue overflow");

endmodule

### hdl/shv_front.sv
// shv_front: tracks byte position, assembles words and classifies each beat
// depends on shv_pkg
module shv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output shv_pkg::q_entry_t    entry
);

    logic [shv_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [shv_pkg::WORD_W-1:0] shift_reg, shift_next;
    logic                       overrun_reg, overrun_next;

    logic                       in_range;
    logic [shv_pkg::WORD_W-1:0] new_shift;
    logic [shv_pkg::POS_W-1:0]  list_off;
    logic [shv_pkg::POS_W-1:0]  list_idx;
    logic [shv_pkg::POS_W-1:0]  sig_off;

    assign in_range  = pos_reg < shv_pkg::POS_W'(shv_pkg::PAGE_BYTES);
    assign new_shift = {shift_reg[shv_pkg::WORD_W-9:0], data_byte};
    assign list_off  = pos_reg - shv_pkg::POS_W'(shv_pkg::LIST_OFFSET);
    assign list_idx  = list_off >> 2;
    assign sig_off   = pos_reg - shv_pkg::POS_W'(shv_pkg::SIG_START);

    always_comb
    begin
        entry.last         = last_byte;
        entry.right_length = in_range && !overrun_reg
                             && pos_reg == shv_pkg::POS_W'(shv_pkg::PAGE_BYTES - 1);
        entry.sig_bad      = in_range && pos_reg >= shv_pkg::POS_W'(shv_pkg::SIG_START)
                             && data_byte != shv_pkg::sig_char(sig_off[3:0]);
        entry.idx          = list_idx[shv_pkg::IDX_W-1:0];
        entry.word         = new_shift;
        if (!in_range)
            entry.kind = shv_pkg::OP_NONE;
        else if (pos_reg == shv_pkg::POS_W'(shv_pkg::VER_AT + 3))
            entry.kind = shv_pkg::OP_VERSION;
        else if (pos_reg == shv_pkg::POS_W'(shv_pkg::LAST_AT + 3))
            entry.kind = shv_pkg::OP_LAST;
        else if (pos_reg == shv_pkg::POS_W'(shv_pkg::COUNT_AT + 3))
            entry.kind = shv_pkg::OP_COUNT;
        else if (pos_reg >= shv_pkg::POS_W'(shv_pkg::LIST_OFFSET) && list_off[1:0] == 2'd3
                 && list_idx < shv_pkg::POS_W'(shv_pkg::MAX_BAD))
            entry.kind = shv_pkg::OP_LIST;
        else
            entry.kind = shv_pkg::OP_NONE;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        overrun_next = overrun_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next     = '0;
                shift_next   = '0;
                overrun_next = 1'b0;
            end
            else if (in_range)
            begin
                pos_next   = pos_reg + shv_pkg::POS_W'(1);
                shift_next = new_shift;
            end
            else
                overrun_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            shift_reg   <= '0;
            overrun_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            shift_reg   <= shift_next;
            overrun_reg <= overrun_next;
        end
    end

endmodule

### hdl/shv_queue.sv
// shv_queue: two-entry queue of classified beats between front and back
// depends on shv_pkg
module shv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  shv_pkg::q_entry_t    push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output shv_pkg::q_entry_t    pop_data
);

    shv_pkg::q_entry_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/shv_back.sv
// shv_back: applies classified beats to the header checks and registers the verdict
// depends on shv_pkg
module shv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [shv_pkg::DEV_W-1:0]   dev_pages,
    input  logic                        q_valid,
    input  shv_pkg::q_entry_t           q_data,
    output logic                        q_pop,
    shv_verdict_if.source               out_ch
);

    logic                       order_big_reg, order_big_next;
    logic                       version_ok_reg, version_ok_next;
    logic [shv_pkg::WORD_W-1:0] last_page_reg, last_page_next;
    logic [shv_pkg::WORD_W-1:0] count_reg, count_next;
    logic [shv_pkg::WORD_W-1:0] prev_bad_reg, prev_bad_next;
    logic                       list_err_reg, list_err_next;
    logic                       sig_match_reg, sig_match_next;

    logic                       out_valid_reg, out_valid_next;
    shv_pkg::status_t           status_reg, status_next;
    logic                       big_reg, big_next;
    logic [shv_pkg::WORD_W-1:0] page_reg, page_next;
    logic [shv_pkg::BPC_W-1:0]  bpc_reg, bpc_next;

    logic [shv_pkg::WORD_W-1:0] word;
    logic                       sig_ok;
    logic                       header_bad;
    shv_pkg::status_t           verdict;

    assign word  = order_big_reg ? q_data.word : shv_pkg::swap32(q_data.word);
    assign q_pop = q_valid && (!q_data.last || !out_valid_reg || out_ch.ready);

    // only the signature can still change on a correctly placed last beat
    assign sig_ok     = sig_match_reg && !q_data.sig_bad;
    assign header_bad = !version_ok_reg || last_page_reg == '0
                        || {1'b0, last_page_reg} >= dev_pages
                        || count_reg > shv_pkg::WORD_W'(shv_pkg::MAX_BAD)
                        || list_err_reg;

    always_comb
    begin
        if (!q_data.right_length)
            verdict = shv_pkg::ST_INVALID;
        else if (!sig_ok)
            verdict = shv_pkg::ST_NO_SIG;
        else if (header_bad)
            verdict = shv_pkg::ST_INVALID;
        else
            verdict = shv_pkg::ST_VALID;
    end

    always_comb
    begin
        order_big_next  = order_big_reg;
        version_ok_next = version_ok_reg;
        last_page_next  = last_page_reg;
        count_next      = count_reg;
        prev_bad_next   = prev_bad_reg;
        list_err_next   = list_err_reg;
        sig_match_next  = sig_match_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        status_next     = status_reg;
        big_next        = big_reg;
        page_next       = page_reg;
        bpc_next        = bpc_reg;

        if (q_pop)
        begin
            unique case (q_data.kind)
                shv_pkg::OP_VERSION:
                begin
                    if (shv_pkg::swap32(q_data.word) == shv_pkg::WORD_W'(1))
                    begin
                        order_big_next  = 1'b0;
                        version_ok_next = 1'b1;
                    end
                    else if (q_data.word == shv_pkg::WORD_W'(1))
                    begin
                        order_big_next  = 1'b1;
                        version_ok_next = 1'b1;
                    end
                    else
                    begin
                        order_big_next  = 1'b0;
                        version_ok_next = 1'b0;
                    end
                end
                shv_pkg::OP_LAST:  last_page_next = word;
                shv_pkg::OP_COUNT: count_next = word;
                shv_pkg::OP_LIST:
                begin
                    if (shv_pkg::WORD_W'(q_data.idx) < count_reg)
                    begin
                        if (word == '0 || word > last_page_reg || word <= prev_bad_reg)
                            list_err_next = 1'b1;
                        prev_bad_next = word;
                    end
                end
                default: ;
            endcase
            if (q_data.sig_bad)
                sig_match_next = 1'b0;

            if (q_data.last)
            begin
                out_valid_next  = 1'b1;
                status_next     = verdict;
                big_next        = verdict == shv_pkg::ST_VALID && order_big_reg;
                page_next       = verdict == shv_pkg::ST_VALID ? last_page_reg : '0;
                bpc_next        = verdict == shv_pkg::ST_VALID
                                  ? count_reg[shv_pkg::BPC_W-1:0] : '0;
                // back to reset values for the next header
                order_big_next  = 1'b0;
                version_ok_next = 1'b0;
                last_page_next  = '0;
                count_next      = '0;
                prev_bad_next   = '0;
                list_err_next   = 1'b0;
                sig_match_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_big_reg  <= 1'b0;
            version_ok_reg <= 1'b0;
            last_page_reg  <= '0;
            count_reg      <= '0;
            prev_bad_reg   <= '0;
            list_err_reg   <= 1'b0;
            sig_match_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            order_big_reg  <= order_big_next;
            version_ok_reg <= version_ok_next;
            last_page_reg  <= last_page_next;
            count_reg      <= count_next;
            prev_bad_reg   <= prev_bad_next;
            list_err_reg   <= list_err_next;
            sig_match_reg  <= sig_match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        big_reg    <= big_next;
        page_reg   <= page_next;
        bpc_reg    <= bpc_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.big_endian     = big_reg;
    assign out_ch.last_page      = page_reg;
    assign out_ch.bad_page_count = bpc_reg;

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench of swap_header_validator_unit
// drives whole and broken swap header pages byte by byte and checks every verdict
// depends on shv_pkg, shv_if and the rtl of swap_header_validator_unit
`timescale 1ns / 100ps

module tb_top;
    import shv_pkg::*;

    // the trailing signature of a good page, first character in the top byte
    localparam logic [79:0] SWAP_MAGIC = "SWAPSPACE2";

    // one verdict as the block should give it
    typedef struct packed {
        status_t             status;
        logic                big_endian;
        logic [WORD_W-1:0]   last_page;
        logic [BPC_W-1:0]    bad_page_count;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [DEV_W-1:0] cfg_wr_data;

    shv_byte_if    in_ch();
    shv_verdict_if out_ch();

    swap_header_validator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // idle and stall rates of the current phase, in percent
    int src_idle_pct;
    int snk_stall_pct;
    int fail_count;

    // verdicts worked out for accepted last beats, oldest first
    verdict_t expected_verdicts[$];

    // device page count as last written to the block
    logic [DEV_W-1:0] page_limit;

    // header tracking of the predictor, cleared after each verdict
    int unsigned       hdr_pos;
    logic [WORD_W-1:0] tail_word;
    logic              words_big;
    logic              version_seen;
    logic [WORD_W-1:0] last_page_w;
    logic [WORD_W-1:0] count_w;
    logic [WORD_W-1:0] prev_bad;
    logic              list_broken;
    logic              sig_intact;
    logic              overrun;

    // page image that the stimulus tasks build and then send
    logic [7:0] page_img[$];
    logic              img_big;
    logic [WORD_W-1:0] img_last;
    int                img_list_n;

    // free running clock, 4 ns period
    initial begin
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("swap_header_validator_unit verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] reorder(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // expected character at signature offset k; anything past the text is zero
    function automatic logic [7:0] magic_byte(input int unsigned k);
        return (k < 10) ? SWAP_MAGIC[8*(9-k) +: 8] : 8'h00;
    endfunction

    task automatic clear_tracking();
        hdr_pos      = 0;
        tail_word    = '0;
        words_big    = 1'b0;
        version_seen = 1'b0;
        last_page_w  = '0;
        count_w      = '0;
        prev_bad     = '0;
        list_broken  = 1'b0;
        sig_intact   = 1'b1;
        overrun      = 1'b0;
    endtask

    // fold one accepted header beat into the tracking; a last beat yields a verdict
    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        logic [WORD_W-1:0] word;
        int unsigned       idx;
        logic              fits;
        verdict_t          v;
        fits = 1'b0;
        if (hdr_pos < PAGE_BYTES) begin
            tail_word = {tail_word[23:0], b};
            word = words_big ? tail_word : reorder(tail_word);
            if (hdr_pos == VER_AT + 3) begin
                // version must read 1 in one of the two byte orders
                if (reorder(tail_word) == 32'd1) begin
                    words_big    = 1'b0;
                    version_seen = 1'b1;
                end
                else if (tail_word == 32'd1) begin
                    words_big    = 1'b1;
                    version_seen = 1'b1;
                end
                else begin
                    words_big    = 1'b0;
                    version_seen = 1'b0;
                end
            end
            else if (hdr_pos == LAST_AT + 3) begin
                last_page_w = word;
            end
            else if (hdr_pos == COUNT_AT + 3) begin
                count_w = word;
            end
            else if (hdr_pos >= LIST_OFFSET && (hdr_pos - LIST_OFFSET) % 4 == 3) begin
                idx = (hdr_pos - LIST_OFFSET) / 4;
                // only the listed entries count, and only those within the list's capacity
                if (idx < count_w && idx < MAX_BAD) begin
                    if (word == 0 || word > last_page_w || word <= prev_bad)
                        list_broken = 1'b1;
                    prev_bad = word;
                end
            end
            if (hdr_pos >= SIG_START && b != magic_byte(hdr_pos - SIG_START))
                sig_intact = 1'b0;
            fits = !overrun && hdr_pos == PAGE_BYTES - 1;
            hdr_pos++;
        end
        else begin
            // beats past the page only spoil the length
            overrun = 1'b1;
        end

        if (is_last) begin
            if (!fits)
                v.status = ST_INVALID;
            else if (!sig_intact)
                v.status = ST_NO_SIG;
            else if (!version_seen || last_page_w == 0 || {1'b0, last_page_w} >= page_limit ||
                     count_w > MAX_BAD || list_broken)
                v.status = ST_INVALID;
            else
                v.status = ST_VALID;
            v.big_endian     = (v.status == ST_VALID) && words_big;
            v.last_page      = (v.status == ST_VALID) ? last_page_w : '0;
            v.bad_page_count = (v.status == ST_VALID) ? count_w[BPC_W-1:0] : '0;
            expected_verdicts.push_back(v);
            clear_tracking();
        end
    endtask

    // compare one taken verdict with the oldest expectation
    task automatic check_verdict();
        verdict_t want;
        if (expected_verdicts.size() == 0) begin
            $error("verdict with none expected: status %0d", out_ch.status);
            fail_count++;
        end
        else begin
            want = expected_verdicts.pop_front();
            if (out_ch.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, out_ch.status);
                fail_count++;
            end
            if (out_ch.big_endian !== want.big_endian) begin
                $error("big_endian: expected %0d, got %0d", want.big_endian, out_ch.big_endian);
                fail_count++;
            end
            if (out_ch.last_page !== want.last_page) begin
                $error("last_page: expected %08h, got %08h", want.last_page, out_ch.last_page);
                fail_count++;
            end
            if (out_ch.bad_page_count !== want.bad_page_count) begin
                $error("bad_page_count: expected %0d, got %0d",
                       want.bad_page_count, out_ch.bad_page_count);
                fail_count++;
            end
        end
    endtask

    // both channels sampled at the rising edge; inputs only move on the falling one
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                predict_byte(in_ch.data_byte, in_ch.last_byte);
            if (out_ch.valid && out_ch.ready)
                check_verdict();
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // ---------------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------------

    // send one header beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        in_ch.last_byte = is_last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_page();
        for (int i = 0; i < page_img.size(); i++)
            send_byte(page_img[i], i == page_img.size() - 1);
    endtask

    // hold the sender until every verdict is in, then let the pipe settle
    task automatic drain_verdicts();
        in_ch.valid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // device page count, only written with nothing in flight
    task automatic load_page_limit(input logic [DEV_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        page_limit = value;
    endtask

    // ---------------------------------------------------------------------
    // page building
    // ---------------------------------------------------------------------

    task automatic fill_noise(input int n);
        page_img.delete();
        repeat (n) page_img.push_back(8'($urandom));
    endtask

    task automatic put_word(input int off, input logic [WORD_W-1:0] w, input logic big);
        for (int i = 0; i < 4; i++)
            page_img[off+i] = big ? w[31-8*i -: 8] : w[8*i +: 8];
    endtask

    task automatic trim_page(input int len);
        while (page_img.size() > len)
            void'(page_img.pop_back());
    endtask

    // a well formed page: version 1, the given words, a rising bad page list
    // that stays within last page, and the signature; the rest is noise
    task automatic form_header(input logic big, input logic [WORD_W-1:0] lastp,
                               input logic [WORD_W-1:0] count);
        longint unsigned prev_v;
        longint unsigned avail;
        longint unsigned span;
        longint unsigned step;
        fill_noise(PAGE_BYTES);
        put_word(VER_AT, 32'd1, big);
        put_word(LAST_AT, lastp, big);
        put_word(COUNT_AT, count, big);
        img_list_n = (count < MAX_BAD) ? int'(count) : MAX_BAD;
        if (lastp < img_list_n)
            img_list_n = int'(lastp);
        prev_v = 0;
        for (int i = 0; i < img_list_n; i++) begin
            // leave room for the entries still to come
            avail = lastp - prev_v - (img_list_n - i - 1);
            span  = 2 * avail / (img_list_n - i);
            if (span == 0)
                span = 1;
            step = 1 + ($urandom % span);
            if (step > avail)
                step = avail;
            prev_v += step;
            put_word(LIST_OFFSET + 4 * i, prev_v[31:0], big);
        end
        for (int k = 0; k < SIGNATURE_BYTES; k++)
            page_img[SIG_START+k] = magic_byte(k);
        img_big  = big;
        img_last = lastp;
    endtask

    // spoil entry i of the list: 0 zero, 1 above last page, 2 repeat of the one before
    task automatic spoil_list(input int i, input int how);
        case (how)
            0: put_word(LIST_OFFSET + 4 * i, 32'd0, img_big);
            1: put_word(LIST_OFFSET + 4 * i, img_last + 32'd1, img_big);
            default:
                for (int j = 0; j < 4; j++)
                    page_img[LIST_OFFSET+4*i+j] = page_img[LIST_OFFSET+4*(i-1)+j];
        endcase
    endtask

    // random well formed page whose last page mostly fits the device
    task automatic form_random_header();
        longint unsigned upper;
        logic [WORD_W-1:0] lastp;
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] room;
        if (page_limit == 0)
            upper = 0;
        else
            upper = (page_limit - 1 > 33'h0_FFFF_FFFF) ? 64'hFFFF_FFFF : page_limit - 1;
        if (upper == 0)
            lastp = $urandom_range(0, 50);
        else
            case ($urandom_range(0, 3))
                0: lastp = upper[31:0];
                1: lastp = 1 + $urandom_range(0, (upper - 1 < 2000) ? upper - 1 : 2000);
                default: lastp = 1 + ($urandom % upper);
            endcase
        room = (lastp < MAX_BAD) ? lastp : MAX_BAD;
        case ($urandom_range(0, 9))
            0: count = 0;
            1: count = room;
            2: count = MAX_BAD + $urandom_range(1, 3);
            3: count = $urandom;
            default: count = $urandom_range(0, room);
        endcase
        form_header($urandom_range(0, 1), lastp, count);
    endtask

    // one random header: mostly well formed, some with one defect, some broken
    task automatic random_header();
        int pick;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            form_random_header();
        end
        else if (pick < 75) begin
            form_random_header();
            case ($urandom_range(0, 4))
                0: page_img[SIG_START+$urandom_range(0, SIGNATURE_BYTES-1)] ^= 8'($urandom_range(1, 255));
                1: begin
                    w = $urandom;
                    if (w == 32'd1 || w == 32'h0100_0000)
                        w = 32'd2;
                    put_word(VER_AT, w, img_big);
                end
                2: put_word(LAST_AT, 32'd0, img_big);
                3: put_word(LAST_AT, (page_limit > 33'h0_FFFF_FFFF) ? 32'd0 : page_limit[31:0],
                            img_big);
                default:
                    if (img_list_n >= 2)
                        spoil_list($urandom_range(1, img_list_n - 1),
                                   (img_last == 32'hFFFF_FFFF) ? 2 : $urandom_range(0, 2));
                    else
                        put_word(COUNT_AT, MAX_BAD + $urandom_range(1, 100), img_big);
            endcase
        end
        else if (pick < 90) begin
            // cut short, mostly very short
            form_random_header();
            trim_page(($urandom_range(0, 9) < 7) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, PAGE_BYTES - 1));
        end
        else if (pick < 95) begin
            // good page with stray bytes after it
            form_random_header();
            repeat ($urandom_range(1, 8)) page_img.push_back(8'($urandom));
        end
        else begin
            fill_noise(PAGE_BYTES);
        end
        send_page();
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // single beat headers, one byte short, stray bytes past the page, a good page
    task automatic check_length_rules();
        drain_verdicts();
        load_page_limit(33'h1_0000_0000);
        page_img = {8'hFF};
        send_page();
        page_img = {8'h00};
        send_page();
        form_header(1'b0, 32'd100, 32'd5);
        trim_page(PAGE_BYTES - 1);
        send_page();
        form_header(1'b0, 32'd100, 32'd5);
        repeat (3) page_img.push_back(8'($urandom));
        send_page();
        form_header(1'b0, 32'd100, 32'd5);
        send_page();
    endtask

    // both byte orders and version words that read 1 in neither
    task automatic check_byte_order();
        drain_verdicts();
        form_header(1'b1, 32'h89AB_CDEF, 32'd300);
        send_page();
        form_header(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_page();
        form_header(1'b0, 32'd500, 32'd10);
        put_word(VER_AT, 32'd0, 1'b0);
        send_page();
        form_header(1'b1, 32'd500, 32'd10);
        put_word(VER_AT, 32'h0100_0001, 1'b1);
        send_page();
    endtask

    // signature defects and their place in the precedence
    task automatic check_signature();
        drain_verdicts();
        form_header(1'b0, 32'd900, 32'd20);
        page_img[SIG_START] = 8'h73;
        send_page();
        form_header(1'b1, 32'd900, 32'd20);
        page_img[PAGE_BYTES-1] = 8'hCD;
        send_page();
        // a missing signature outranks a bad version
        form_header(1'b0, 32'd900, 32'd20);
        put_word(VER_AT, 32'd7, 1'b0);
        page_img[SIG_START+4] = 8'h00;
        send_page();
        // a wrong length outranks a missing signature
        form_header(1'b0, 32'd900, 32'd20);
        page_img[SIG_START+1] = 8'h00;
        page_img.push_back(8'h55);
        send_page();
    endtask

    // full, overfull and exact lists, and each kind of bad entry
    task automatic check_bad_page_list();
        drain_verdicts();
        form_header(1'b0, 32'd5000, MAX_BAD);
        send_page();
        form_header(1'b1, 32'd5000, MAX_BAD + 1);
        send_page();
        form_header(1'b0, 32'd20, 32'd20);
        send_page();
        form_header(1'b0, 32'd800, 32'd40);
        spoil_list(0, 0);
        send_page();
        form_header(1'b1, 32'd800, 32'd40);
        spoil_list(39, 1);
        send_page();
        form_header(1'b0, 32'd800, 32'd40);
        spoil_list(17, 2);
        send_page();
        form_header(1'b1, 32'd800, 32'hFFFF_FFFF);
        send_page();
    endtask

    // last page against the device size, register at zero and at the top of the 32-bit page range
    task automatic check_page_limit();
        drain_verdicts();
        load_page_limit(33'd0);
        form_header(1'b0, 32'd10, 32'd3);
        send_page();
        drain_verdicts();
        load_page_limit(33'd1000);
        form_header(1'b0, 32'd999, 32'd30);
        send_page();
        form_header(1'b1, 32'd1000, 32'd30);
        send_page();
        form_header(1'b0, 32'd0, 32'd0);
        send_page();
        drain_verdicts();
        load_page_limit(33'h0_FFFF_FFFF);
        form_header(1'b1, 32'hFFFF_FFFE, 32'd2);
        send_page();
        form_header(1'b0, 32'hFFFF_FFFF, 32'd2);
        send_page();
    endtask

    // random headers under one idle pattern and one device size
    task automatic run_random_phase(input int idle, input int stall,
                                    input logic [DEV_W-1:0] limit, input int headers);
        drain_verdicts();
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        load_page_limit(limit);
        repeat (headers) random_header();
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        fail_count      = 0;
        page_limit      = '0;
        clear_tracking();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling
        check_length_rules();
        check_byte_order();
        check_signature();
        check_bad_page_list();
        check_page_limit();

        // random part: no gaps, sender gaps, receiver stalls, then both
        run_random_phase(0, 0, 33'h1_0000_0000, 12);
        run_random_phase(54, 0, {1'($urandom_range(0, 1)), 32'($urandom)}, 12);
        run_random_phase(0, 54, 33'd5000, 12);
        run_random_phase(28, 28, 33'h0_FFFF_FFFF, 12);

        drain_verdicts();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("swap_header_validator_unit verification clean");
        else
            $display("swap_header_validator_unit verification failed");
        $finish;
    end

endmodule

### filelist.f
hdl/shv_pkg.sv
hdl/shv_if.sv
hdl/shv_front.sv
hdl/shv_queue.sv
hdl/shv_back.sv
hdl/swap_header_validator_unit.sv
dv/tb_top.sv
